/* hdl/normalized_lms_fir_q15_defines.svh */
// ----------------------------------------------------------------------------
// normalized_lms_fir_q15 assertion macros
// Shared property shapes for the concurrent checks of the filter block.
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_LMS_FIR_Q15_DEFINES_SVH
`define NORMALIZED_LMS_FIR_Q15_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/nlms_fir_pkg.sv */
// ----------------------------------------------------------------------------
// nlms_fir_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package nlms_fir_pkg;

    localparam int MAX_TAPS = 32;
    localparam int TAP_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W    = 32 + TAP_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [5:0] NUM_TAPS_RESET = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POST_SHIFT = 2'd2;

    // Multiplier operand selection.
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_DEP  = 3'd1;
    localparam logic [2:0] MUL_X    = 3'd2;
    localparam logic [2:0] MUL_MAC  = 3'd3;
    localparam logic [2:0] MUL_ERR  = 3'd4;
    localparam logic [2:0] MUL_GAIN = 3'd5;
    localparam logic [2:0] MUL_UPD  = 3'd6;

    // What the registered product is used for, as carried beside it in act_reg.
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_ENERGY_SUB = 3'd1;
    localparam logic [2:0] ACT_ENERGY_ADD = 3'd2;
    localparam logic [2:0] ACT_ACC        = 3'd3;
    localparam logic [2:0] ACT_EMU        = 3'd4;
    localparam logic [2:0] ACT_GAIN       = 3'd5;
    localparam logic [2:0] ACT_UPDATE     = 3'd6;

    typedef struct packed {
        logic [2:0]       mul_sel;
        logic [2:0]       act;
        logic [TAP_W-1:0] tap;
        logic             take_sample;
        logic             load_coef;
        logic             err_load;
        logic             dep_load;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic [TAP_W-1:0] last_tap;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/nlms_fir_ctrl.sv */
// ----------------------------------------------------------------------------
// nlms_fir_ctrl
// Sequencer that takes coefficient loads and walks the energy, filter, error, gain and update steps of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_fir_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_kind,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire nlms_fir_pkg::sts_t  sts,
    output nlms_fir_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ENERGY = 4'd1;
    localparam logic [3:0] S_MAC    = 4'd2;
    localparam logic [3:0] S_FORM   = 4'd3;
    localparam logic [3:0] S_ERR    = 4'd4;
    localparam logic [3:0] S_MU     = 4'd5;
    localparam logic [3:0] S_MU_W   = 4'd6;
    localparam logic [3:0] S_GAIN   = 4'd7;
    localparam logic [3:0] S_GAIN_W = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_UPD_W  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [nlms_fir_pkg::TAP_W-1:0] tap_reg;
    logic [nlms_fir_pkg::TAP_W-1:0] tap_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tap_next       = tap_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.mul_sel    = nlms_fir_pkg::MUL_NONE;
        cmd.act        = nlms_fir_pkg::ACT_NONE;
        cmd.tap        = tap_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                tap_next = '0;
                if (in_valid)
                begin
                    if (in_kind)
                    begin
                        cmd.load_coef = 1'b1;
                    end
                    else
                    begin
                        cmd.take_sample = 1'b1;
                        state_next      = S_ENERGY;
                    end
                end
            end
            S_ENERGY:
            begin
                // Step 0 removes the departed sample, step 1 adds the new one.
                if (tap_reg == '0)
                begin
                    cmd.mul_sel = nlms_fir_pkg::MUL_DEP;
                    cmd.act     = nlms_fir_pkg::ACT_ENERGY_SUB;
                    tap_next    = tap_reg + 1'b1;
                end
                else
                begin
                    cmd.mul_sel = nlms_fir_pkg::MUL_X;
                    cmd.act     = nlms_fir_pkg::ACT_ENERGY_ADD;
                    tap_next    = '0;
                    state_next  = S_MAC;
                end
            end
            S_MAC:
            begin
                cmd.mul_sel = nlms_fir_pkg::MUL_MAC;
                cmd.act     = nlms_fir_pkg::ACT_ACC;
                if (tap_reg == sts.last_tap)
                begin
                    tap_next   = '0;
                    state_next = S_FORM;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_FORM:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_load = 1'b1;
                state_next   = S_MU;
            end
            S_MU:
            begin
                cmd.mul_sel = nlms_fir_pkg::MUL_ERR;
                cmd.act     = nlms_fir_pkg::ACT_EMU;
                state_next  = S_MU_W;
            end
            S_MU_W:
            begin
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.mul_sel = nlms_fir_pkg::MUL_GAIN;
                cmd.act     = nlms_fir_pkg::ACT_GAIN;
                state_next  = S_GAIN_W;
            end
            S_GAIN_W:
            begin
                tap_next   = '0;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.mul_sel = nlms_fir_pkg::MUL_UPD;
                cmd.act     = nlms_fir_pkg::ACT_UPDATE;
                if (tap_reg == sts.last_tap)
                begin
                    tap_next   = '0;
                    state_next = S_UPD_W;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end
            S_UPD_W:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.dep_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/nlms_fir_dp.sv */
// ----------------------------------------------------------------------------
// nlms_fir_dp
// Delay line, coefficients, shared multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nlms_fir_dp
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire nlms_fir_pkg::cmd_t                        cmd,
    output nlms_fir_pkg::sts_t                             sts,
    input  wire logic                                      cfg_we,
    input  wire logic [nlms_fir_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [nlms_fir_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic signed [15:0]                        sample,
    input  wire logic signed [15:0]                        reference,
    input  wire logic [4:0]                                coef_index,
    input  wire logic signed [15:0]                        coef_value,
    output logic signed [15:0]                             filter_out,
    output logic signed [15:0]                             error_out
);

    localparam int                 N     = nlms_fir_pkg::MAX_TAPS;
    localparam int                 TW    = nlms_fir_pkg::TAP_W;
    localparam int                 AW    = nlms_fir_pkg::ACC_W;
    localparam logic signed [15:0] RECIP = 16'sd32767;

    logic [5:0]               num_taps_reg;
    logic signed [15:0]       step_size_reg;
    logic [3:0]               post_shift_reg;

    logic signed [15:0]       dl_reg   [N];
    logic signed [15:0]       coef_reg [N];
    logic signed [15:0]       ref_reg;
    logic signed [15:0]       dep_reg;
    logic [15:0]              energy_reg;
    logic signed [AW-1:0]     acc_reg;
    logic signed [31:0]       prod_reg;
    logic [2:0]               act_reg;
    logic [TW-1:0]            tap_d_reg;
    logic signed [15:0]       y_reg;
    logic signed [15:0]       e_reg;
    logic signed [15:0]       emu_reg;
    logic signed [15:0]       g_reg;
    logic signed [15:0]       out_y_reg;
    logic signed [15:0]       out_e_reg;

    logic [TW-1:0]            last_tap;
    logic [TW-1:0]            dl_addr;
    logic signed [15:0]       dl_rd;
    logic signed [15:0]       mul_a;
    logic signed [15:0]       mul_b;
    logic signed [AW-1:0]     acc_sh;
    logic signed [31:0]       acc_low;
    logic signed [15:0]       y_comb;
    logic [3:0]               norm_sh;
    logic signed [31:0]       gain_sh;
    logic signed [15:0]       gain_sat;
    logic signed [17:0]       upd_sum;
    logic signed [15:0]       upd_sat;

    // Leading-zero count of the energy plus one, less two (not below zero), capped at thirteen.
    function automatic logic [3:0] norm_shift(input logic [15:0] v);
        logic [3:0] s;
        logic       found;
        s     = 4'd0;
        found = 1'b0;
        if (!v[15] && (v != 16'd0))
        begin
            for (int b = 14; b >= 0; b--)
            begin
                if (!found && v[b])
                begin
                    s     = 4'(14 - b);
                    found = 1'b1;
                end
            end
            if (s != 4'd0)
            begin
                s = s - 4'd1;
            end
        end
        return s;
    endfunction

    // A tap count of zero acts as one; counts above the array act as all taps.
    always_comb
    begin
        if (num_taps_reg == 6'd0)
        begin
            last_tap = '0;
        end
        else if (32'(num_taps_reg) > N)
        begin
            last_tap = TW'(N - 1);
        end
        else
        begin
            last_tap = TW'(num_taps_reg - 6'd1);
        end
    end

    assign sts.last_tap = last_tap;
    assign dl_addr      = last_tap - cmd.tap;
    assign dl_rd        = dl_reg[dl_addr];

    always_comb
    begin
        case (cmd.mul_sel)
            nlms_fir_pkg::MUL_DEP:
            begin
                mul_a = dep_reg;
                mul_b = dep_reg;
            end
            nlms_fir_pkg::MUL_X:
            begin
                mul_a = dl_reg[0];
                mul_b = dl_reg[0];
            end
            nlms_fir_pkg::MUL_MAC:
            begin
                mul_a = coef_reg[cmd.tap];
                mul_b = dl_rd;
            end
            nlms_fir_pkg::MUL_ERR:
            begin
                mul_a = e_reg;
                mul_b = step_size_reg;
            end
            nlms_fir_pkg::MUL_GAIN:
            begin
                mul_a = emu_reg;
                mul_b = RECIP;
            end
            nlms_fir_pkg::MUL_UPD:
            begin
                mul_a = g_reg;
                mul_b = dl_rd;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Output scaling: arithmetic shift, keep the low word, saturate.
    always_comb
    begin
        acc_sh  = acc_reg >>> (4'd15 - post_shift_reg);
        acc_low = acc_sh[31:0];
        if (acc_low > 32'sd32767)
        begin
            y_comb = 16'sd32767;
        end
        else if (acc_low < -32'sd32768)
        begin
            y_comb = -16'sd32768;
        end
        else
        begin
            y_comb = acc_low[15:0];
        end
    end

    always_comb
    begin
        norm_sh = norm_shift(energy_reg + 16'd1);
        gain_sh = prod_reg >>> (4'd15 - norm_sh);
        if (gain_sh > 32'sd32767)
        begin
            gain_sat = 16'sd32767;
        end
        else if (gain_sh < -32'sd32768)
        begin
            gain_sat = -16'sd32768;
        end
        else
        begin
            gain_sat = gain_sh[15:0];
        end
    end

    always_comb
    begin
        upd_sum = 18'(coef_reg[tap_d_reg]) + 18'(prod_reg >>> 15);
        if (upd_sum > 18'sd32767)
        begin
            upd_sat = 16'sd32767;
        end
        else if (upd_sum < -18'sd32768)
        begin
            upd_sat = -16'sd32768;
        end
        else
        begin
            upd_sat = upd_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg   <= nlms_fir_pkg::NUM_TAPS_RESET;
            step_size_reg  <= '0;
            post_shift_reg <= '0;
            act_reg        <= nlms_fir_pkg::ACT_NONE;
            energy_reg     <= '0;
            dep_reg        <= '0;
            for (int k = 0; k < N; k++)
            begin
                dl_reg[k]   <= '0;
                coef_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    nlms_fir_pkg::REG_NUM_TAPS:   num_taps_reg   <= cfg_data[5:0];
                    nlms_fir_pkg::REG_STEP_SIZE:  step_size_reg  <= cfg_data;
                    nlms_fir_pkg::REG_POST_SHIFT: post_shift_reg <= cfg_data[3:0];
                    default:                      ;
                endcase
            end

            act_reg <= cmd.act;

            if (cmd.take_sample)
            begin
                dl_reg[0] <= sample;
                for (int k = 1; k < N; k++)
                begin
                    dl_reg[k] <= dl_reg[k-1];
                end
            end

            if (cmd.dep_load)
            begin
                dep_reg <= dl_reg[last_tap];
            end

            case (act_reg)
                nlms_fir_pkg::ACT_ENERGY_SUB: energy_reg <= energy_reg - prod_reg[30:15];
                nlms_fir_pkg::ACT_ENERGY_ADD: energy_reg <= energy_reg + prod_reg[30:15];
                default:                      ;
            endcase

            if (cmd.load_coef && (32'(coef_index) < N))
            begin
                coef_reg[TW'(coef_index)] <= coef_value;
            end
            else if (act_reg == nlms_fir_pkg::ACT_UPDATE)
            begin
                coef_reg[tap_d_reg] <= upd_sat;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        tap_d_reg <= cmd.tap;

        if (cmd.take_sample)
        begin
            ref_reg <= reference;
            acc_reg <= '0;
        end
        else if (act_reg == nlms_fir_pkg::ACT_ACC)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end

        if (cmd.err_load)
        begin
            y_reg <= y_comb;
            e_reg <= ref_reg - y_comb;
        end

        if (act_reg == nlms_fir_pkg::ACT_EMU)
        begin
            emu_reg <= prod_reg[30:15];
        end

        if (act_reg == nlms_fir_pkg::ACT_GAIN)
        begin
            g_reg <= gain_sat;
        end

        if (cmd.out_load)
        begin
            out_y_reg <= y_reg;
            out_e_reg <= e_reg;
        end
    end

    assign filter_out = out_y_reg;
    assign error_out  = out_e_reg;

endmodule

`default_nettype wire

/* hdl/normalized_lms_fir_q15.sv */
// ----------------------------------------------------------------------------
// normalized_lms_fir_q15
// Normalized LMS adaptive FIR filter on Q15 samples with in-place adaptation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_axis    in         tvalid / tready      tuser: kind, tdata: sample fields
//  m_axis    out        tvalid / tready      tdata: filter_out, error_out
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Because a single shared 16x16 multiplier serves every product, a filter
//  transaction runs its steps in order: the energy update for the departed
//  and the new sample, one pass over the taps that forms the sum of products,
//  the error and step gain steps, and a second pass over the taps that
//  updates the coefficients.
//  A coefficient load transaction completes in its acceptance cycle.
//  Reset clears the delay line, coefficients, energy and control state.
//  A finished result waits in an output register, so the next item is taken
//  while the result is stalled; the sequencer only holds at its final step
//  if the previous result has not yet left.
//
`default_nettype none

`include "normalized_lms_fir_q15_defines.svh"

module normalized_lms_fir_q15
(
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,

    // tdata, from bit 0: sample[15:0], reference[31:16], coef_index[36:32],
    // coef_value[52:37], zero fill[55:53].
    input  wire logic [nlms_fir_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // tuser: kind[0] (0 = filter sample, 1 = load one coefficient).
    input  wire logic                                       s_axis_tuser,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,

    // tdata, from bit 0: filter_out[15:0], error_out[31:16].
    output logic [nlms_fir_pkg::OUT_TDATA_W-1:0]            m_axis_tdata,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,

    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [nlms_fir_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [nlms_fir_pkg::CFG_DATA_W-1:0]        cfg_data
);

    nlms_fir_pkg::cmd_t cmd;
    nlms_fir_pkg::sts_t sts;
    logic signed [15:0] filter_out;
    logic signed [15:0] error_out;

    // Configuration writes are always taken and take effect at once, so the user must
    // make them only while no transaction is in flight; the block does not enforce this.
    assign cfg_ready = 1'b1;

    nlms_fir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The input transaction fields are sliced from tdata here and passed to the datapath.
    nlms_fir_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (s_axis_tdata[15:0]),
        .reference  (s_axis_tdata[31:16]),
        .coef_index (s_axis_tdata[36:32]),
        .coef_value (s_axis_tdata[52:37]),
        .filter_out (filter_out),
        .error_out  (error_out)
    );

    assign m_axis_tdata = {error_out, filter_out};

    // A filter transaction keeps the block busy on the following cycle.
    `NLF_ASSERT_NEXT(a_busy_after_sample,
        s_axis_tvalid && s_axis_tready && !s_axis_tuser,
        !s_axis_tready,
        "block took a new transaction right after a filter transaction")

    // A coefficient load never produces a result.
    `NLF_ASSERT_NEXT(a_load_no_result,
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid,
        !m_axis_tvalid,
        "coefficient load produced a result")

    // Tap walks stay inside the window in use.
    `NLF_ASSERT_SAME(a_tap_in_window,
        cmd.mul_sel == nlms_fir_pkg::MUL_MAC || cmd.mul_sel == nlms_fir_pkg::MUL_UPD,
        cmd.tap <= sts.last_tap,
        "tap index beyond the active window")

endmodule

`default_nettype wire
